FILE: rtl/core/conjugate_gradient_solver_assert.svh
// Assertion macros used by the solver engine.
`ifndef CONJUGATE_GRADIENT_SOLVER_ASSERT_SVH
`define CONJUGATE_GRADIENT_SOLVER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define CGS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CGS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/cgs_pkg.sv
package cgs_pkg;

	localparam int MAX_N_DEFAULT = 64;
	localparam int FRAC = 16;
	localparam int SIZE_RESET = 64;
	localparam int TOL_RESET = 43;

	localparam logic [1:0] CMD_MATRIX = 2'd0;
	localparam logic [1:0] CMD_RHS = 2'd1;
	localparam logic [1:0] CMD_SOLVE = 2'd2;

	localparam logic REG_SIZE = 1'b0;
	localparam logic REG_TOL = 1'b1;

	typedef struct packed {
		logic [5:0] element_index;
		logic signed [31:0] solution_value;
		logic last;
		logic converged;
		logic breakdown;
		logic [7:0] iterations;
	} cgs_result_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63]) begin
			sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add64 = s[63:0];
		end
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [64:0] x);
		if ((&x[64:31]) || !(|x[64:31])) begin
			clamp32 = x[31:0];
		end else begin
			clamp32 = x[64] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
	endfunction

	// base plus or minus the product taken back to Q16.16 with floor.
	function automatic logic signed [31:0] axpy(input logic signed [31:0] base,
		input logic signed [63:0] prod, input logic sub);
		logic signed [63:0] t;
		logic signed [64:0] s;
		t = prod >>> FRAC;
		s = sub ? (65'(base) - 65'(t)) : (65'(base) + 65'(t));
		axpy = clamp32(s);
	endfunction

endpackage

FILE: rtl/core/cgs_divider.sv
module cgs_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] num,
	input logic signed [63:0] den,
	output logic busy,
	output logic done,
	output logic signed [31:0] quot
);
	import cgs_pkg::*;

	localparam int STEPS = 64 + FRAC;
	localparam int CNT_W = $clog2(STEPS);

	logic [STEPS-1:0] nsh_q;
	logic [63:0] rem_q;
	logic [63:0] d_q;
	logic [31:0] q_q;
	logic big_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [64:0] rem_sh;
	logic ge;
	logic [32:0] q_next;
	logic [31:0] limit;
	logic [31:0] q_sat;

	assign rem_sh = {rem_q, nsh_q[STEPS-1]};
	assign ge = rem_sh >= {1'b0, d_q};
	assign q_next = {q_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nsh_q <= {(num[63] ? 64'(-num) : 64'(num)), {FRAC{1'b0}}};
			d_q <= den[63] ? 64'(-den) : 64'(den);
			neg_q <= num[63] != den[63];
			rem_q <= '0;
			q_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			nsh_q <= {nsh_q[STEPS-2:0], 1'b0};
			rem_q <= ge ? 64'(rem_sh - {1'b0, d_q}) : rem_sh[63:0];
			q_q <= q_next[31:0];
			big_q <= big_q | q_next[32];
		end
	end

	assign limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign q_sat = (big_q || (q_q > limit)) ? limit : q_q;
	assign quot = (d_q == '0) ? '0 : (neg_q ? 32'(-q_sat) : q_sat);
	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: rtl/core/cgs_engine.sv
`include "conjugate_gradient_solver_assert.svh"

module cgs_engine #(
	parameter int MAX_N = cgs_pkg::MAX_N_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic [5:0] row,
	input logic [5:0] col,
	input logic signed [31:0] value,
	input logic [6:0] size_in_use,
	input logic [31:0] tolerance,
	output logic res_push,
	input logic res_ready,
	output cgs_pkg::cgs_result_t res
);
	import cgs_pkg::*;

	localparam int IW = $clog2(MAX_N);
	localparam int NW = $clog2(MAX_N + 1);
	localparam int CW = $clog2(2 * MAX_N + 1);
	localparam int A_DEPTH = MAX_N * (2 ** IW);
	localparam logic [2:0] DRAIN = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_THRESH, S_CHECK, S_MV, S_SIGMA, S_DIVA,
		S_XR, S_DIVB, S_UPDP, S_EMIT_RD, S_EMIT_WR
	} state_t;

	// Memories.
	logic signed [31:0] a_mem [A_DEPTH];
	logic signed [31:0] rhs_mem [MAX_N];
	logic signed [31:0] x_mem [MAX_N];
	logic signed [31:0] r_mem [MAX_N];
	logic signed [31:0] p_mem [MAX_N];
	logic signed [31:0] v_mem [MAX_N];
	logic signed [31:0] a_rd, rhs_rd, x_rd, r_rd, p_rd, v_rd;

	// Sequencer state.
	state_t state_q;
	logic issue_q;
	logic [2:0] drain_q;
	logic [IW-1:0] k_q, i_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] count_q;
	logic conv_q, brk_q;
	logic [1:0] th_q;
	logic signed [63:0] gamma_q, rhs_e_q;
	logic [63:0] plo_q, phi_q, high_q;
	logic lownz_q;
	logic signed [31:0] coef_q;

	// Pipeline.
	logic v_s1, v_s2, v_s3, v_s4;
	logic [IW-1:0] idx_s1, idx_s2, row_s1, row_s2;
	logic rowend_s1, rowend_s2;
	logic signed [63:0] prod1_s2, prod2_s2, sq_s4;
	logic signed [31:0] bx_s2, br_s2, rn_s3;
	logic signed [63:0] acc_q;

	logic in_pass, issue, last_k, last_i, pass_done, start_solve, below, stop_check;
	logic acc_clr, load_ok;
	logic [NW-1:0] n_eff;
	logic signed [31:0] m1_a, m1_b;
	logic signed [63:0] acc_sum;
	logic signed [31:0] xn, rn, pn;
	logic [31:0] th_op;
	logic [63:0] th_prod;
	logic div_start, div_busy, div_done;
	logic signed [63:0] div_num, div_den;
	logic signed [31:0] div_quot;

	assign in_stall = state_q != S_IDLE;
	assign load_ok = in_valid && !in_stall;
	assign start_solve = load_ok && (cmd == CMD_SOLVE);

	always_comb begin
		if (size_in_use == '0) begin
			n_eff = NW'(1);
		end else if (32'(size_in_use) > MAX_N) begin
			n_eff = NW'(MAX_N);
		end else begin
			n_eff = NW'(size_in_use);
		end
	end

	assign in_pass = (state_q == S_INIT) || (state_q == S_MV) || (state_q == S_SIGMA)
		|| (state_q == S_XR) || (state_q == S_UPDP);
	assign issue = in_pass && issue_q;
	assign last_k = k_q == IW'(n_q - 1'b1);
	assign last_i = i_q == IW'(n_q - 1'b1);
	assign pass_done = in_pass && !issue_q && (drain_q == '0);

	assign below = ($unsigned(gamma_q) < high_q) || (($unsigned(gamma_q) == high_q) && lownz_q);
	assign stop_check = below || (count_q == CW'({n_q, 1'b0}));

	assign div_start = pass_done && (((state_q == S_SIGMA) && (acc_q != '0))
		|| ((state_q == S_XR) && (gamma_q != '0)));
	assign div_num = (state_q == S_SIGMA) ? gamma_q : acc_q;
	assign div_den = (state_q == S_SIGMA) ? acc_q : gamma_q;

	assign acc_clr = start_solve || (pass_done && (state_q == S_MV))
		|| ((state_q == S_CHECK) && !stop_check)
		|| ((state_q == S_DIVA) && div_done);

	assign th_op = (th_q == 2'd0) ? rhs_e_q[31:0] : rhs_e_q[63:32];
	assign th_prod = tolerance * th_op;

	cgs_divider u_div (
		.clk (clk),
		.arst_n (arst_n),
		.start (div_start),
		.num (div_num),
		.den (div_den),
		.busy (div_busy),
		.done (div_done),
		.quot (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= 1'b0;
			drain_q <= '0;
			k_q <= '0;
			i_q <= '0;
			n_q <= NW'(MAX_N);
			count_q <= '0;
			conv_q <= 1'b0;
			brk_q <= 1'b0;
			th_q <= '0;
		end else begin
			if (issue) begin
				if (last_k) begin
					k_q <= '0;
					if (state_q == S_MV) begin
						i_q <= IW'(i_q + 1'b1);
					end
					if ((state_q != S_MV) || last_i) begin
						issue_q <= 1'b0;
						drain_q <= DRAIN;
					end
				end else begin
					k_q <= IW'(k_q + 1'b1);
				end
			end else if (in_pass && (drain_q != '0)) begin
				drain_q <= 3'(drain_q - 1'b1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start_solve) begin
						n_q <= n_eff;
						count_q <= '0;
						conv_q <= 1'b0;
						brk_q <= 1'b0;
						k_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					if (pass_done) begin
						rhs_e_q <= acc_q;
						gamma_q <= acc_q;
						th_q <= '0;
						if (acc_q == '0) begin
							conv_q <= 1'b1;
							state_q <= S_EMIT_RD;
						end else begin
							state_q <= S_THRESH;
						end
					end
				end
				S_THRESH: begin
					th_q <= 2'(th_q + 1'b1);
					priority case (th_q)
						2'd0: plo_q <= th_prod;
						2'd1: phi_q <= th_prod;
						default: begin
							high_q <= 64'(phi_q + (plo_q >> 32));
							lownz_q <= plo_q[31:0] != '0;
							state_q <= S_CHECK;
						end
					endcase
				end
				S_CHECK: begin
					if (stop_check) begin
						conv_q <= below;
						k_q <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						k_q <= '0;
						i_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_MV;
					end
				end
				S_MV: begin
					if (pass_done) begin
						k_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_SIGMA;
					end
				end
				S_SIGMA: begin
					if (pass_done) begin
						if (acc_q == '0) begin
							brk_q <= 1'b1;
							state_q <= S_EMIT_RD;
						end else begin
							state_q <= S_DIVA;
						end
					end
				end
				S_DIVA: begin
					if (div_done) begin
						coef_q <= div_quot;
						k_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_XR;
					end
				end
				S_XR: begin
					if (pass_done) begin
						count_q <= CW'(count_q + 1'b1);
						gamma_q <= acc_q;
						if (gamma_q == '0) begin
							brk_q <= 1'b1;
							state_q <= S_EMIT_RD;
						end else begin
							state_q <= S_DIVB;
						end
					end
				end
				S_DIVB: begin
					if (div_done) begin
						coef_q <= div_quot;
						k_q <= '0;
						issue_q <= 1'b1;
						state_q <= S_UPDP;
					end
				end
				S_UPDP: begin
					if (pass_done) begin
						state_q <= S_CHECK;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (res_ready) begin
						if (last_k) begin
							k_q <= '0;
							state_q <= S_IDLE;
						end else begin
							k_q <= IW'(k_q + 1'b1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Host loads and vector read ports.
	always_ff @(posedge clk) begin
		if (load_ok && (cmd == CMD_MATRIX) && (32'(row) < MAX_N) && (32'(col) < MAX_N)) begin
			a_mem[{IW'(row), IW'(col)}] <= value;
		end
		if (load_ok && (cmd == CMD_RHS) && (32'(row) < MAX_N)) begin
			rhs_mem[IW'(row)] <= value;
		end
		a_rd <= a_mem[{i_q, k_q}];
		rhs_rd <= rhs_mem[k_q];
	end

	// Each index is written from the s2 pipeline registers after it was read and never read again in
	// the same pass; the drain between passes keeps passes from overlapping.
	always_ff @(posedge clk) begin
		if (v_s2 && ((state_q == S_INIT) || (state_q == S_XR))) begin
			x_mem[idx_s2] <= (state_q == S_INIT) ? 32'sd0 : xn;
			r_mem[idx_s2] <= (state_q == S_INIT) ? bx_s2 : rn;
		end
		if (v_s2 && ((state_q == S_INIT) || (state_q == S_UPDP))) begin
			p_mem[idx_s2] <= (state_q == S_INIT) ? bx_s2 : pn;
		end
		if (v_s2 && (state_q == S_MV) && rowend_s2) begin
			v_mem[row_s2] <= clamp32(65'(acc_sum >>> FRAC));
		end
		x_rd <= x_mem[k_q];
		r_rd <= r_mem[k_q];
		p_rd <= p_mem[k_q];
		v_rd <= v_mem[k_q];
	end

	always_comb begin
		unique case (state_q)
			S_INIT: begin
				m1_a = rhs_rd;
				m1_b = rhs_rd;
			end
			S_MV: begin
				m1_a = a_rd;
				m1_b = p_rd;
			end
			S_SIGMA: begin
				m1_a = p_rd;
				m1_b = v_rd;
			end
			default: begin
				m1_a = coef_q;
				m1_b = p_rd;
			end
		endcase
	end

	assign acc_sum = sat_add64(acc_q, prod1_s2);
	assign xn = axpy(bx_s2, prod1_s2, 1'b0);
	assign rn = axpy(br_s2, prod2_s2, 1'b1);
	assign pn = axpy(bx_s2, prod1_s2, 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (state_q == S_XR);
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= k_q;
		row_s1 <= i_q;
		rowend_s1 <= last_k;
		idx_s2 <= idx_s1;
		row_s2 <= row_s1;
		rowend_s2 <= rowend_s1;
		prod1_s2 <= m1_a * m1_b;
		prod2_s2 <= coef_q * v_rd;
		bx_s2 <= (state_q == S_INIT) ? rhs_rd : ((state_q == S_XR) ? x_rd : r_rd);
		br_s2 <= r_rd;
		rn_s3 <= rn;
		sq_s4 <= rn_s3 * rn_s3;
		priority if (acc_clr) begin
			acc_q <= '0;
		end else if (v_s4) begin
			acc_q <= sat_add64(acc_q, sq_s4);
		end else if (v_s2 && (state_q == S_MV)) begin
			acc_q <= rowend_s2 ? 64'sd0 : acc_sum;
		end else if (v_s2 && ((state_q == S_INIT) || (state_q == S_SIGMA))) begin
			acc_q <= acc_sum;
		end
	end

	assign res_push = (state_q == S_EMIT_WR) && res_ready;
	assign res.element_index = 6'(k_q);
	assign res.solution_value = x_rd;
	assign res.last = last_k;
	assign res.converged = conv_q;
	assign res.breakdown = brk_q;
	assign res.iterations = 8'(count_q);

	`CGS_ASSERT(a_div_idle, div_start |-> !div_busy, "divider started while busy")
	`CGS_ASSERT(a_count_bound, count_q <= CW'({n_q, 1'b0}), "iteration count beyond limit")
	`CGS_ASSERT(a_drained, pass_done |-> !(v_s1 || v_s2 || v_s3 || v_s4),
		"pass ended with words in flight")
	`CGS_ASSERT(a_push_ready, res_push |-> (res_ready && (state_q == S_EMIT_WR)),
		"result pushed into a full output stage")

endmodule

FILE: rtl/core/conjugate_gradient_solver.sv
// Conjugate-gradient solver for A x = b in Q16.16. While idle it takes one load word
// per cycle (matrix entry, right-hand-side entry) and a solve word starts the run;
// input then stalls until the last solution word has entered the output register.
// A solve runs a set-up pass over the right-hand side, then iterations in which
// one multiply-accumulate path walks the matrix memory one entry a cycle, each vector
// pass is followed by a drain of the pipeline, and the two quotients come from a
// bit-serial divider. The N solution words follow, each through a read state and
// a write state, as each needs its own read of the solution memory.
module conjugate_gradient_solver #(
	parameter int MAX_N = cgs_pkg::MAX_N_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic [5:0] row,
	input logic [5:0] col,
	input logic signed [31:0] value,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] element_index,
	output logic signed [31:0] solution_value,
	output logic last,
	output logic converged,
	output logic breakdown,
	output logic [7:0] iterations
);
	import cgs_pkg::*;

	logic [6:0] size_q;
	logic [31:0] tol_q;
	logic out_valid_q;
	cgs_result_t res_q;
	cgs_result_t res;
	logic res_push, res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 7'(SIZE_RESET);
			tol_q <= 32'(TOL_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE: size_q <= cfg_data[6:0];
				REG_TOL: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q <= res;
		end
	end

	cgs_engine #(
		.MAX_N (MAX_N)
	) u_engine (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd (cmd),
		.row (row),
		.col (col),
		.value (value),
		.size_in_use (size_q),
		.tolerance (tol_q),
		.res_push (res_push),
		.res_ready (res_ready),
		.res (res)
	);

	assign out_valid = out_valid_q;
	assign element_index = res_q.element_index;
	assign solution_value = res_q.solution_value;
	assign last = res_q.last;
	assign converged = res_q.converged;
	assign breakdown = res_q.breakdown;
	assign iterations = res_q.iterations;

endmodule
